[rtl/sorted_key_table_insert_defines.svh]
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Shared assertion forms for the sorted key table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_DEFINES_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key table package
// Word types, table geometry and command codes.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 16;
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = $clog2(CAPACITY + 1);

    localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             full_res;
        logic [POS_W-1:0] entry_total;
    } rsp_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi_p1;
    } step_t;

endpackage

[rtl/sorted_key_table_insert.sv]
// ----------------------------------------------------------------------------
// Sorted key table with binary search insert
// Keeps up to 256 key/handle entries in ascending key order.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result word is shown on rsp for one cycle with rsp_valid, and
// busy falls in that same cycle. The result cannot be held off. Timing
// comes from the single registered read port of the key memory: each
// search probe issues its read in S_RD and compares in S_CMP, an insert
// then shifts the entries above the position up one entry per cycle and
// ends with the final write in S_INS, and clear finishes in S_RD. The
// tables need no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "sorted_key_table_insert_defines.svh"

module sorted_key_table_insert
    import skt_pkg::*;
#(
    parameter int KEY_BITS    = 64,
    parameter int HANDLE_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic rsp_valid,
    output rsp_t rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;

    logic [KEY_BITS-1:0]    key_mem [CAPACITY];
    logic [HANDLE_BITS-1:0] handle_mem [CAPACITY];

    logic [2:0]             state_reg, state_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [POS_W-1:0]       count_reg, count_next;
    logic                   pend_reg, pend_next;
    rsp_t                   rsp_reg, rsp_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [POS_W-1:0]       hi_p1_reg, hi_p1_next;
    logic [POS_W-1:0]       mid_reg, mid_next;
    logic [POS_W-1:0]       where_reg, where_next;
    logic                   hit_reg, hit_next;
    logic [POS_W-1:0]       i_reg, i_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [KEY_BITS-1:0]    rd_key_reg;
    logic [HANDLE_BITS-1:0] rd_handle_reg;

    logic [HANDLE_BITS+HANDLE_W-1:0] handle_ext;
    logic [POS_W:0]         mid_sum;
    logic [POS_W-1:0]       mid;
    logic [POS_W-1:0]       i_dec;
    step_t                  step;

    logic                   we;
    logic [ADDR_W-1:0]      wa;
    logic [ADDR_W-1:0]      ra;
    logic [KEY_BITS-1:0]    wkey;
    logic [HANDLE_BITS-1:0] whandle;
    logic                   search_done;
    logic                   hit_val;
    logic [POS_W-1:0]       where_val;
    logic                   finish;

    assign handle_ext = {{HANDLE_BITS{1'b0}}, req.handle};
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_p1_reg} - (POS_W + 1)'(1);
    assign mid        = mid_sum[POS_W:1];
    assign i_dec      = i_reg - POS_W'(1);

    skt_search_step #(
        .KEY_BITS (KEY_BITS)
    ) u_step (
        .probe_key  (rd_key_reg),
        .search_key (key_reg),
        .mid        (mid_reg),
        .lo         (lo_reg),
        .hi_p1      (hi_p1_reg),
        .step       (step)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = 1'b0;
        count_next     = count_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        lo_next        = lo_reg;
        hi_p1_next     = hi_p1_reg;
        mid_next       = mid_reg;
        where_next     = where_reg;
        hit_next       = hit_reg;
        i_next         = i_reg;
        pend_addr_next = pend_addr_reg;
        we             = 1'b0;
        wa             = pend_addr_reg;
        ra             = mid[ADDR_W-1:0];
        wkey           = rd_key_reg;
        whandle        = rd_handle_reg;
        search_done    = 1'b0;
        hit_val        = 1'b0;
        where_val      = lo_reg;
        finish         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = req.command;
                    key_next    = req.key[KEY_BITS-1:0];
                    handle_next = handle_ext[HANDLE_BITS-1:0];
                    lo_next     = '0;
                    hi_p1_next  = count_reg;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    count_next = '0;
                    rsp_next   = '0;
                    finish     = 1'b1;
                end
                else if (lo_reg < hi_p1_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    search_done = 1'b1;
                    where_val   = lo_reg;
                end
            end
            S_CMP:
            begin
                lo_next    = step.lo;
                hi_p1_next = step.hi_p1;
                if (step.hit)
                begin
                    search_done = 1'b1;
                    hit_val     = 1'b1;
                    where_val   = mid_reg;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_SHIFT:
            begin
                // read entry i-1 now, write it to entry i next cycle
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (i_reg > where_reg)
                begin
                    ra             = i_dec[ADDR_W-1:0];
                    i_next         = i_dec;
                    pend_next      = 1'b1;
                    pend_addr_next = i_reg[ADDR_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_INS;
                    end
                end
            end
            S_INS:
            begin
                we                   = 1'b1;
                wa                   = where_reg[ADDR_W-1:0];
                wkey                 = key_reg;
                whandle              = handle_reg;
                count_next           = count_reg + POS_W'(1);
                rsp_next.found       = hit_reg;
                rsp_next.position    = where_reg;
                rsp_next.full_res    = 1'b0;
                rsp_next.entry_total = count_reg + POS_W'(1);
                finish               = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (search_done)
        begin
            where_next = where_val;
            hit_next   = hit_val;
            if (cmd_reg == CMD_INSERT && count_reg != CAP_COUNT)
            begin
                i_next     = count_reg;
                pend_next  = 1'b0;
                state_next = S_SHIFT;
            end
            else
            begin
                rsp_next.found       = hit_val;
                rsp_next.position    = where_val;
                rsp_next.full_res    = cmd_reg == CMD_INSERT;
                rsp_next.entry_total = count_reg;
                finish               = 1'b1;
            end
        end

        if (finish)
        begin
            state_next     = S_IDLE;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        handle_reg    <= handle_next;
        lo_reg        <= lo_next;
        hi_p1_reg     <= hi_p1_next;
        mid_reg       <= mid_next;
        where_reg     <= where_next;
        hit_reg       <= hit_next;
        i_reg         <= i_next;
        pend_addr_reg <= pend_addr_next;
    end

    // key and handle memories, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wa]    <= wkey;
            handle_mem[wa] <= whandle;
        end
        rd_key_reg    <= key_mem[ra];
        rd_handle_reg <= handle_mem[ra];
    end

    assign busy      = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SKT_ASSERT_IMP(a_done_with_word, clk, rst_n, $fell(busy), rsp_valid, "busy fell without result word")
    `SKT_ASSERT_IMP(a_total_bound, clk, rst_n, rsp_valid, rsp.entry_total <= CAP_COUNT, "entry total above capacity")
    `SKT_ASSERT_IMP(a_full_total, clk, rst_n, rsp_valid && rsp.full_res, rsp.entry_total == CAP_COUNT, "full flagged below capacity")
    `SKT_ASSERT_NXT(a_cmp_bounds, clk, rst_n, state_reg == S_RD && cmd_reg != CMD_CLEAR && lo_reg < hi_p1_reg, state_reg == S_CMP && mid_reg < hi_p1_reg, "probe outside search bounds")

endmodule

[rtl/skt_search_step.sv]
// ----------------------------------------------------------------------------
// Sorted key table search step
// One binary search probe: compares the probed key and narrows the bounds.
// ----------------------------------------------------------------------------
module skt_search_step
    import skt_pkg::*;
#(
    parameter int KEY_BITS = 64
)
(
    input  logic [KEY_BITS-1:0] probe_key,
    input  logic [KEY_BITS-1:0] search_key,
    input  logic [POS_W-1:0]    mid,
    input  logic [POS_W-1:0]    lo,
    input  logic [POS_W-1:0]    hi_p1,
    output step_t               step
);

    logic greater;

    assign greater = probe_key > search_key;

    always_comb
    begin
        step.hit   = probe_key == search_key;
        step.lo    = greater ? lo : mid + POS_W'(1);
        step.hi_p1 = greater ? mid : hi_p1;
    end

endmodule

[verif/sorted_key_table_insert_checker.sv]
// ----------------------------------------------------------------------------
// Sorted key table checker
// Watches the command and result channels and keeps its own sorted table.
// Each accepted command word is applied to that table to predict the result,
// and each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_insert_checker
    import skt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic rsp_valid,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding
);

    logic [KEY_W-1:0]    key_tab    [CAPACITY];
    logic [HANDLE_W-1:0] handle_tab [CAPACITY];
    int                  fill;
    rsp_t                predicted_rsp [$];

    // clear, or binary search and then insert, on the shadow table
    function automatic rsp_t search_and_update(input req_t w);
        rsp_t r;
        int   lo;
        int   hi;
        int   mid;
        int   pos;
        logic hit;
        r   = '0;
        hit = 1'b0;
        lo  = 0;
        mid = 0;
        hi  = fill - 1;
        if (w.command == CMD_CLEAR)
        begin
            fill = 0;
            return r;
        end
        while (lo <= hi && !hit)
        begin
            mid = (lo + hi) / 2;
            if (key_tab[mid] == w.key)
                hit = 1'b1;
            else if (key_tab[mid] > w.key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        pos = hit ? mid : lo;
        if (w.command == CMD_INSERT)
        begin
            if (fill >= CAPACITY)
                r.full_res = 1'b1;
            else
            begin
                for (int i = fill; i > pos; i--)
                begin
                    key_tab[i]    = key_tab[i-1];
                    handle_tab[i] = handle_tab[i-1];
                end
                key_tab[pos]    = w.key;
                handle_tab[pos] = w.handle;
                fill++;
            end
        end
        r.found       = hit;
        r.position    = POS_W'(pos);
        r.entry_total = POS_W'(fill);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            predicted_rsp.delete();
            fill   = 0;
            errors = 0;
        end
        else
        begin
            if (rsp_valid)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %p",
                             $time, rsp);
                    errors++;
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    compare_field("found", POS_W'(want.found), POS_W'(rsp.found));
                    compare_field("position", want.position, rsp.position);
                    compare_field("full_res", POS_W'(want.full_res), POS_W'(rsp.full_res));
                    compare_field("entry_total", want.entry_total, rsp.entry_total);
                end
            end
            if (start && !busy)
                predicted_rsp.push_back(search_and_update(req));
        end
        outstanding = predicted_rsp.size();
    end

endmodule

[verif/sorted_key_table_insert_tb.sv]
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives find, insert, clear and the unused command into the table: a short
// directed run over empty, edge-key and duplicate cases, then random fill
// phases from empty up to a full table, sent in bursts with random gaps.
// The checker does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_insert_tb;
    import skt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1700;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic rsp_valid;
    rsp_t rsp;
    int   errors;
    int   outstanding;
    int   stall_cycles = 0;
    int   burst_left   = 0;
    logic [KEY_W-1:0] known_keys [$];

    always #1 clk = ~clk;

    sorted_key_table_insert i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    sorted_key_table_insert_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || rsp_valid)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic req_t word_of(input logic [CMD_W-1:0] cmd,
                                     input logic [KEY_W-1:0] key,
                                     input logic [HANDLE_W-1:0] handle);
        req_t w;
        w.command = cmd;
        w.key     = key;
        w.handle  = handle;
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            4, 5: k = KEY_W'($urandom_range(0, 63));
            6:
            begin
                case ($urandom_range(0, 4))
                    0: k = '0;
                    1: k = '1;
                    2: k = KEY_W'(1);
                    3: k = {KEY_W{1'b1}} - KEY_W'(1);
                    default: k = {1'b1, {(KEY_W-1){1'b0}}};
                endcase
            end
            7, 8:
                if (known_keys.size() > 0)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            9:
                if (known_keys.size() > 0)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)]
                        + ($urandom_range(0, 1) ? KEY_W'(1) : {KEY_W{1'b1}});
            default: ;
        endcase
        return k;
    endfunction

    // hold start until the word is taken, leave at the falling edge after
    task automatic send_word(input req_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue(input req_t w);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = $urandom_range(0, 3);
                5, 6, 7, 8:    gap = $urandom_range(0, 40);
                default:       gap = $urandom_range(0, 300);
            endcase
            burst_left = $urandom_range(1, 60);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        if (w.command == CMD_CLEAR)
            known_keys.delete();
        else if (w.command == CMD_INSERT && known_keys.size() < 512)
            known_keys.push_back(w.key);
        send_word(w);
    endtask

    initial
    begin
        int sent;
        int target;
        int inserted;
        logic [CMD_W-1:0] cmd;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, edge keys, duplicates, unused command
        issue(word_of(CMD_FIND, '0, 16'h0000));
        issue(word_of(CMD_FIND, '1, 16'hffff));
        issue(word_of(CMD_UNUSED, KEY_W'(5), 16'h1234));
        issue(word_of(CMD_INSERT, KEY_W'(1000), 16'h0000));
        issue(word_of(CMD_INSERT, '0, 16'hffff));
        issue(word_of(CMD_INSERT, '1, 16'haaaa));
        issue(word_of(CMD_INSERT, KEY_W'(1000), 16'h5555));
        issue(word_of(CMD_INSERT, KEY_W'(500), 16'h0001));
        issue(word_of(CMD_INSERT, KEY_W'(1500), 16'h8000));
        issue(word_of(CMD_FIND, KEY_W'(1000), 16'h0000));
        issue(word_of(CMD_FIND, KEY_W'(999), 16'h0000));
        issue(word_of(CMD_FIND, KEY_W'(1001), 16'h0000));
        issue(word_of(CMD_FIND, '0, 16'h0000));
        issue(word_of(CMD_FIND, '1, 16'h0000));
        issue(word_of(CMD_FIND, {1'b1, {(KEY_W-1){1'b0}}}, 16'h0000));
        issue(word_of(CMD_UNUSED, KEY_W'(1000), 16'hffff));
        issue(word_of(CMD_CLEAR, '1, 16'hffff));
        issue(word_of(CMD_FIND, KEY_W'(1000), 16'h0000));
        issue(word_of(CMD_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 16'h7fff));
        issue(word_of(CMD_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 16'h0f0f));
        issue(word_of(CMD_FIND, {1'b0, {(KEY_W-1){1'b1}}}, 16'h0000));
        issue(word_of(CMD_CLEAR, '0, 16'h0000));

        // fill phases; the first one always runs past a full table
        sent = 0;
        for (int phase = 0; sent < RANDOM_WORDS; phase++)
        begin
            issue(word_of(CMD_CLEAR, pick_key(), HANDLE_W'($urandom)));
            sent++;
            target = (phase == 0 || $urandom_range(0, 7) == 0)
                     ? CAPACITY + $urandom_range(2, 12) : $urandom_range(0, 48);
            inserted = 0;
            while (inserted < target && sent < RANDOM_WORDS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        cmd = CMD_INSERT;
                        inserted++;
                    end
                    6, 7, 8: cmd = CMD_FIND;
                    default: cmd = CMD_UNUSED;
                endcase
                issue(word_of(cmd, pick_key(), HANDLE_W'($urandom)));
                sent++;
            end
            repeat ($urandom_range(1, 8))
            begin
                issue(word_of(CMD_FIND, pick_key(), HANDLE_W'($urandom)));
                sent++;
            end
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
